// File: hw/rtl/clt_pkg.sv
// Shared types, token and error codes, and keyword tables for the calculator tokenizer.
// Used by the front end, the back end, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  localparam int unsigned LINE_BITS_DEFAULT = 16;
  localparam int unsigned LINE_OUT_BITS     = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned OBUF_DEPTH        = 4;

  localparam logic [30:0] LIMIT_RESET = 31'd2147483646;

  // Token codes.
  localparam logic [4:0] TK_EOF    = 5'd0;
  localparam logic [4:0] TK_NUM    = 5'd1;
  localparam logic [4:0] TK_PLUS   = 5'd2;
  localparam logic [4:0] TK_MINUS  = 5'd3;
  localparam logic [4:0] TK_TIMES  = 5'd4;
  localparam logic [4:0] TK_DIV    = 5'd5;
  localparam logic [4:0] TK_POWER  = 5'd6;
  localparam logic [4:0] TK_ASSIGN = 5'd7;
  localparam logic [4:0] TK_LPAREN = 5'd8;
  localparam logic [4:0] TK_RPAREN = 5'd9;
  localparam logic [4:0] TK_LBRACK = 5'd10;
  localparam logic [4:0] TK_RBRACK = 5'd11;
  localparam logic [4:0] TK_MEM    = 5'd12;
  localparam logic [4:0] TK_GOTO   = 5'd13;
  localparam logic [4:0] TK_IF     = 5'd14;
  localparam logic [4:0] TK_PRINT  = 5'd15;
  localparam logic [4:0] TK_LABEL  = 5'd16;
  localparam logic [4:0] TK_COLON  = 5'd17;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CHAR  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Keyword kinds.
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_GOTO  = 2'd1;
  localparam logic [1:0] KW_IF    = 2'd2;
  localparam logic [1:0] KW_PRINT = 2'd3;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_DIGIT,
    CLS_STAR,
    CLS_KEYWORD,
    CLS_SINGLE,
    CLS_BAD,
    CLS_END
  } char_class_e;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    char_class_e cls;
    logic [7:0]  char_code;
    logic [3:0]  digit;
    logic [4:0]  kind;
    logic [1:0]  kw;
  } item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [30:0] number_value;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  function automatic logic [2:0] kw_length(input logic [1:0] k);
    case (k)
      KW_GOTO:  return 3'd4;
      KW_IF:    return 3'd2;
      KW_PRINT: return 3'd5;
      default:  return 3'd0;
    endcase
  endfunction

  function automatic logic [4:0] kw_token(input logic [1:0] k);
    case (k)
      KW_GOTO:  return TK_GOTO;
      KW_IF:    return TK_IF;
      KW_PRINT: return TK_PRINT;
      default:  return TK_EOF;
    endcase
  endfunction

  // Letter expected at position p of keyword k.
  function automatic logic [7:0] kw_letter(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] letter;
    letter = 8'h00;
    case (k)
      KW_GOTO: begin
        case (p)
          3'd0:    letter = "g";
          3'd1:    letter = "o";
          3'd2:    letter = "t";
          3'd3:    letter = "o";
          default: letter = 8'h00;
        endcase
      end
      KW_IF: begin
        case (p)
          3'd0:    letter = "i";
          3'd1:    letter = "f";
          default: letter = 8'h00;
        endcase
      end
      KW_PRINT: begin
        case (p)
          3'd0:    letter = "p";
          3'd1:    letter = "r";
          3'd2:    letter = "i";
          3'd3:    letter = "n";
          3'd4:    letter = "t";
          default: letter = 8'h00;
        endcase
      end
      default: letter = 8'h00;
    endcase
    return letter;
  endfunction

  function automatic result_t make_result(input logic [4:0]  kind,
                                          input logic [30:0] value,
                                          input logic [15:0] line,
                                          input logic [1:0]  err);
    result_t r;
    r.token_kind   = kind;
    r.number_value = value;
    r.line_number  = line;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/clt_if.sv
// Valid/ready channel interfaces for the tokenizer: character input and token output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [30:0] number_value;
  logic [15:0] line_number;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output number_value,
                  output line_number, output error_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input line_number, input error_code, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/calc_language_tokenizer.sv
// An accepted character is registered in the front-end queue, then its tokens in the output
// buffer. Throughput: one character per cycle while the buffer has room. Both tokens of a
// number or lone star ended by another token are buffered together; output takes one token
// per cycle. Reset (asynchronous, active low) empties both queues, puts the scanner in idle,
// sets the line counter to one, clears the halt flag and loads the default number limit.
// Top level of the calculator tokenizer; depends on clt_pkg, clt_if, clt_front, clt_back.
`timescale 1ns / 1ps
`default_nettype none

// The design has two parts. The front end classifies each incoming character (digit,
// blank, newline, star, keyword start, single-character token, illegal, end of input)
// and pushes it into a two-entry queue, so input ready depends only on queue occupancy.
// The back end pops one classified item per cycle, updates the scanner state (pending
// number, pending star, partly spelled keyword, line counter, halt flag) and writes up
// to two tokens into a four-entry output buffer. It pops only while the buffer has room
// for two tokens, so a stalled consumer backs up through the queue to the input.
// After an error token the block halts: characters are still accepted but dropped
// until the next reset.
module calc_language_tokenizer import clt_pkg::*; #(
  parameter int unsigned LINE_COUNTER_BITS = LINE_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  clt_in_if.sink      in_i,
  clt_out_if.source   out_o
);

  // Classified characters from the front end to the back end.
  logic  item_valid;
  item_t item;
  logic  item_pop;

  clt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // The number limit register lives in the back end, next to the compare that uses it.
  clt_back #(
    .LINE_COUNTER_BITS (LINE_COUNTER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/clt_front.sv
// Front end: accepts characters, classifies them and holds them in a short queue.
// Depends on clt_pkg and clt_in_if.
`timescale 1ns / 1ps
`default_nettype none

module clt_front import clt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  clt_in_if.sink in_i,
  output logic   item_valid_o,
  output item_t  item_o,
  input  logic   item_pop_i
);

  localparam int unsigned PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t                 queue_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  item_t                 item_d;
  logic                  push, pop;

  always_comb begin
    item_d           = '0;
    item_d.char_code = in_i.char_code;
    item_d.digit     = 4'(in_i.char_code - 8'h30);
    item_d.cls       = CLS_BAD;
    if (in_i.end_of_input) begin
      item_d.cls = CLS_END;
    end else begin
      case (in_i.char_code)
        8'h20, 8'h09: item_d.cls = CLS_SPACE;
        8'h0A:        item_d.cls = CLS_NEWLINE;
        "*":          item_d.cls = CLS_STAR;
        "g": begin
          item_d.cls = CLS_KEYWORD;
          item_d.kw  = KW_GOTO;
        end
        "i": begin
          item_d.cls = CLS_KEYWORD;
          item_d.kw  = KW_IF;
        end
        "p": begin
          item_d.cls = CLS_KEYWORD;
          item_d.kw  = KW_PRINT;
        end
        "+": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_PLUS;   end
        "-": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_MINUS;  end
        "/": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_DIV;    end
        "=": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_ASSIGN; end
        "(": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_LPAREN; end
        ")": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_RPAREN; end
        "[": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_LBRACK; end
        "]": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_RBRACK; end
        "m": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_MEM;    end
        "L": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_LABEL;  end
        ":": begin item_d.cls = CLS_SINGLE; item_d.kind = TK_COLON;  end
        default: begin
          if (in_i.char_code >= "0" && in_i.char_code <= "9") begin
            item_d.cls = CLS_DIGIT;
          end else begin
            item_d.cls = CLS_BAD;
          end
        end
      endcase
    end
  end

  assign in_i.ready   = (count_q != COUNT_BITS'(QUEUE_DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + COUNT_BITS'(push) - COUNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/clt_back.sv
// Back end: runs the scanner state on classified items and buffers the resulting tokens.
// Depends on clt_pkg and clt_out_if.
`timescale 1ns / 1ps
`default_nettype none

module clt_back import clt_pkg::*; #(
  parameter int unsigned LINE_COUNTER_BITS = LINE_BITS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [30:0]   cfg_wdata_i,
  input  logic          item_valid_i,
  input  item_t         item_i,
  output logic          item_pop_o,
  clt_out_if.source     out_o
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_NUMBER  = 2'd1;
  localparam logic [1:0] MODE_STAR    = 2'd2;
  localparam logic [1:0] MODE_KEYWORD = 2'd3;

  localparam int unsigned OPTR_BITS = $clog2(OBUF_DEPTH);
  localparam int unsigned OCNT_BITS = $clog2(OBUF_DEPTH + 1);

  logic [1:0]                   mode_q, mode_d;
  logic [1:0]                   kw_kind_q, kw_kind_d;
  logic [2:0]                   kw_pos_q, kw_pos_d;
  logic [30:0]                  acc_q, acc_d;
  logic [LINE_COUNTER_BITS-1:0] line_q, line_d;
  logic                         halted_q, halted_d;
  logic [30:0]                  limit_q;

  result_t                      obuf_q [OBUF_DEPTH];
  logic [OPTR_BITS-1:0]         obuf_wr_q, obuf_rd_q, post_ptr;
  logic [OCNT_BITS-1:0]         obuf_cnt_q;

  logic [LINE_OUT_BITS-1:0]     line_sat;
  logic [34:0]                  times_ten;
  logic [2:0]                   kw_len, kw_pos_inc;
  logic                         process, out_pop, do_idle;
  logic                         pre_v, post_v;
  result_t                      pre_r, post_r;

  // The reported line saturates at the width of the output field.
  if (LINE_COUNTER_BITS > LINE_OUT_BITS) begin : g_line_wide
    assign line_sat = (|line_q[LINE_COUNTER_BITS-1:LINE_OUT_BITS]) ? '1
                                                                   : line_q[LINE_OUT_BITS-1:0];
  end else begin : g_line_narrow
    assign line_sat = LINE_OUT_BITS'(line_q);
  end

  // acc * 10 + digit as two shifted copies.
  assign times_ten = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'b0, item_i.digit};

  assign kw_len     = kw_length(kw_kind_q);
  assign kw_pos_inc = kw_pos_q + 3'd1;

  // An item is taken only when the buffer has room for both of its possible results.
  assign item_pop_o = item_valid_i && (obuf_cnt_q <= OCNT_BITS'(OBUF_DEPTH - 2));
  assign process    = item_pop_o && !halted_q;

  always_comb begin
    mode_d    = mode_q;
    kw_kind_d = kw_kind_q;
    kw_pos_d  = kw_pos_q;
    acc_d     = acc_q;
    line_d    = line_q;
    halted_d  = halted_q;
    pre_v     = 1'b0;
    post_v    = 1'b0;
    pre_r     = make_result(TK_EOF, '0, line_sat, ERR_NONE);
    post_r    = make_result(TK_EOF, '0, line_sat, ERR_NONE);
    do_idle   = 1'b0;

    if (process) begin
      if (item_i.cls == CLS_END) begin
        if (mode_q == MODE_KEYWORD) begin
          halted_d = 1'b1;
          mode_d   = MODE_IDLE;
          post_v   = 1'b1;
          post_r   = make_result(TK_EOF, '0, line_sat, ERR_CHAR);
        end else begin
          if (mode_q == MODE_NUMBER) begin
            pre_v = 1'b1;
            pre_r = make_result(TK_NUM, acc_q, line_sat, ERR_NONE);
          end else if (mode_q == MODE_STAR) begin
            pre_v = 1'b1;
            pre_r = make_result(TK_TIMES, '0, line_sat, ERR_NONE);
          end
          post_v    = 1'b1;
          post_r    = make_result(TK_EOF, '0, line_sat, ERR_NONE);
          mode_d    = MODE_IDLE;
          acc_d     = '0;
          kw_kind_d = KW_NONE;
          kw_pos_d  = '0;
        end
      end else begin
        case (mode_q)
          MODE_NUMBER: begin
            if (item_i.cls == CLS_DIGIT) begin
              if (times_ten > {4'b0, limit_q}) begin
                halted_d = 1'b1;
                mode_d   = MODE_IDLE;
                post_v   = 1'b1;
                post_r   = make_result(TK_EOF, '0, line_sat, ERR_RANGE);
              end else begin
                acc_d = times_ten[30:0];
              end
            end else begin
              pre_v   = 1'b1;
              pre_r   = make_result(TK_NUM, acc_q, line_sat, ERR_NONE);
              acc_d   = '0;
              do_idle = 1'b1;
            end
          end
          MODE_STAR: begin
            mode_d = MODE_IDLE;
            if (item_i.cls == CLS_STAR) begin
              post_v = 1'b1;
              post_r = make_result(TK_POWER, '0, line_sat, ERR_NONE);
            end else begin
              pre_v   = 1'b1;
              pre_r   = make_result(TK_TIMES, '0, line_sat, ERR_NONE);
              do_idle = 1'b1;
            end
          end
          MODE_KEYWORD: begin
            if (kw_kind_q == KW_NONE || kw_pos_q >= kw_len ||
                item_i.char_code != kw_letter(kw_kind_q, kw_pos_q)) begin
              halted_d = 1'b1;
              mode_d   = MODE_IDLE;
              post_v   = 1'b1;
              post_r   = make_result(TK_EOF, '0, line_sat, ERR_CHAR);
            end else begin
              kw_pos_d = kw_pos_inc;
              if (kw_pos_inc == kw_len) begin
                mode_d    = MODE_IDLE;
                kw_kind_d = KW_NONE;
                kw_pos_d  = '0;
                post_v    = 1'b1;
                post_r    = make_result(kw_token(kw_kind_q), '0, line_sat, ERR_NONE);
              end
            end
          end
          default: do_idle = 1'b1;
        endcase
      end

      // Character seen with no token pending.
      if (do_idle) begin
        mode_d = MODE_IDLE;
        case (item_i.cls)
          CLS_SPACE: ;
          CLS_NEWLINE: begin
            if (line_q != '1) begin
              line_d = line_q + 1'b1;
            end
          end
          CLS_DIGIT: begin
            acc_d = {27'b0, item_i.digit};
            if ({27'b0, item_i.digit} > limit_q) begin
              halted_d = 1'b1;
              post_v   = 1'b1;
              post_r   = make_result(TK_EOF, '0, line_sat, ERR_RANGE);
            end else begin
              mode_d = MODE_NUMBER;
            end
          end
          CLS_STAR: mode_d = MODE_STAR;
          CLS_KEYWORD: begin
            kw_kind_d = item_i.kw;
            kw_pos_d  = 3'd1;
            mode_d    = MODE_KEYWORD;
          end
          CLS_SINGLE: begin
            post_v = 1'b1;
            post_r = make_result(item_i.kind, '0, line_sat, ERR_NONE);
          end
          default: begin
            halted_d = 1'b1;
            post_v   = 1'b1;
            post_r   = make_result(TK_EOF, '0, line_sat, ERR_CHAR);
          end
        endcase
      end
    end

    pre_r.last_of_run  = !post_v;
    post_r.last_of_run = 1'b1;
  end

  assign post_ptr = obuf_wr_q + OPTR_BITS'(pre_v);

  assign out_o.valid        = (obuf_cnt_q != '0);
  assign out_o.token_kind   = obuf_q[obuf_rd_q].token_kind;
  assign out_o.number_value = obuf_q[obuf_rd_q].number_value;
  assign out_o.line_number  = obuf_q[obuf_rd_q].line_number;
  assign out_o.error_code   = obuf_q[obuf_rd_q].error_code;
  assign out_o.last_of_run  = obuf_q[obuf_rd_q].last_of_run;
  assign out_pop            = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      kw_kind_q  <= KW_NONE;
      kw_pos_q   <= '0;
      acc_q      <= '0;
      line_q     <= LINE_COUNTER_BITS'(1);
      halted_q   <= 1'b0;
      limit_q    <= LIMIT_RESET;
      obuf_wr_q  <= '0;
      obuf_rd_q  <= '0;
      obuf_cnt_q <= '0;
    end else begin
      mode_q     <= mode_d;
      kw_kind_q  <= kw_kind_d;
      kw_pos_q   <= kw_pos_d;
      acc_q      <= acc_d;
      line_q     <= line_d;
      halted_q   <= halted_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      obuf_wr_q  <= obuf_wr_q + OPTR_BITS'(pre_v) + OPTR_BITS'(post_v);
      obuf_rd_q  <= obuf_rd_q + OPTR_BITS'(out_pop);
      obuf_cnt_q <= obuf_cnt_q + OCNT_BITS'(pre_v) + OCNT_BITS'(post_v)
                    - OCNT_BITS'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_v) begin
      obuf_q[obuf_wr_q] <= pre_r;
    end
    if (post_v) begin
      obuf_q[post_ptr] <= post_r;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/clt_checker.sv
// Port-level checker for the calculator tokenizer, bound to the top level.
// Depends on clt_pkg and calc_language_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module clt_checker import clt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_i,
  input logic [30:0] number_value_i,
  input logic [15:0] line_number_i,
  input logic [1:0]  error_code_i,
  input logic        last_of_run_i
);

  // A token held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i) &&
      $stable(number_value_i) && $stable(line_number_i) && $stable(error_code_i) &&
      $stable(last_of_run_i))
    else $error("output token changed while stalled");

  // An error is always the final token of its character, with no kind or value.
  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != ERR_NONE |->
      token_kind_i == TK_EOF && number_value_i == '0 && last_of_run_i)
    else $error("malformed error token");

  // Only number tokens carry a value.
  a_value_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i != TK_NUM |-> number_value_i == '0)
    else $error("value on a non-number token");

  // End of file closes the run of its input.
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i == TK_EOF |-> last_of_run_i)
    else $error("end-of-file token not last of its run");

  // Lines count from one.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> line_number_i != '0)
    else $error("line number zero");

endmodule

bind calc_language_tokenizer clt_checker u_clt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .number_value_i (out_o.number_value),
  .line_number_i  (out_o.line_number),
  .error_code_i   (out_o.error_code),
  .last_of_run_i  (out_o.last_of_run)
);

`default_nettype wire

// File: verif/tb_calc_language_tokenizer.sv
// Self-checking testbench for the calculator tokenizer: characters in, tokens out.
// Depends on clt_pkg and clt_if from the RTL and on the calc_language_tokenizer top level.
`timescale 1ns / 1ps

// The bench feeds characters through the input channel and keeps its own model of the
// scanner. Every accepted character runs through that model, which appends the tokens it
// should cause to a queue of expected tokens; the output side pops the oldest one for each
// token the block hands over and compares all five fields.
//
// Order of the run:
//   - A short table of directed characters under the reset limit. It covers every single
//     character token, star and double star, all three keywords, a number ended by another
//     token, and an end of input that flushes a pending star while its byte is ignored.
//   - Random text with the limit at one, then at a random middle value
//     (including one long hold-off on the output side), then at its reset value.
//   - A last part with no idling: a few newlines, more random text, and finally one
//     error. An error halts the block until reset, and reset is applied only once, so
//     each run ends with exactly one error picked at random (unknown character, broken
//     keyword, end inside a keyword, or a number over the limit), followed by a few
//     items that must cause nothing at all.
module tb_calc_language_tokenizer;
  import clt_pkg::*;

  localparam int unsigned LINE_COUNTER_BITS = LINE_BITS_DEFAULT;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES    = 8;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DIRECTED_ROWS    = 29;

  // Scanner modes of the checking model.
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_STAR,
    SCAN_KEYWORD
  } scan_mode_e;

  // One directed character. Where typed is set, kind is the last token the character
  // must cause, as read straight off the language definition.
  typedef struct {
    logic [7:0] ch;
    bit         eoi;
    bit         typed;
    logic [4:0] kind;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [30:0] cfg_wdata;

  clt_in_if  in_if ();
  clt_out_if out_if ();

  calc_language_tokenizer #(
    .LINE_COUNTER_BITS(LINE_COUNTER_BITS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Scanner state of the checking model, at its reset values.
  scan_mode_e                   scan_mode    = SCAN_IDLE;
  logic [1:0]                   kw_kind      = KW_NONE;
  logic [2:0]                   kw_pos       = '0;
  logic [30:0]                  num_acc      = '0;
  logic [LINE_COUNTER_BITS-1:0] line_count   = 1;
  bit                           halted       = 1'b0;
  logic [30:0]                  number_limit = LIMIT_RESET;

  // Keyword spellings and the tokens they give, indexed by keyword kind.
  string      kw_spelling [4] = '{"", "goto", "if", "print"};
  logic [4:0] kw_result   [4] = '{TK_EOF, TK_GOTO, TK_IF, TK_PRINT};

  string single_chars = "+-/=()[]m:L";
  string blank_chars  = " \t\n";

  result_t    expected_tokens [$];
  int         step_results;
  logic [4:0] step_last_kind;
  int         mismatches = 0;
  int         items_sent = 0;
  bit         prev_char_digit = 1'b0;
  bit         idling_on = 1'b1;
  bit         hold_off_pending = 1'b0;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    '{"+",   1'b0, 1'b1, TK_PLUS},
    '{"9",   1'b0, 1'b0, TK_EOF},
    '{"-",   1'b0, 1'b1, TK_MINUS},   // The pending 9 goes out first.
    '{"0",   1'b0, 1'b0, TK_EOF},
    '{"*",   1'b0, 1'b1, TK_NUM},     // Ends the zero and leaves a star pending.
    '{"*",   1'b0, 1'b1, TK_POWER},
    '{"*",   1'b0, 1'b0, TK_EOF},
    '{"/",   1'b0, 1'b1, TK_DIV},     // A lone star, then the slash.
    '{"=",   1'b0, 1'b1, TK_ASSIGN},
    '{"(",   1'b0, 1'b1, TK_LPAREN},
    '{")",   1'b0, 1'b1, TK_RPAREN},
    '{"[",   1'b0, 1'b1, TK_LBRACK},
    '{"]",   1'b0, 1'b1, TK_RBRACK},
    '{"m",   1'b0, 1'b1, TK_MEM},
    '{"L",   1'b0, 1'b1, TK_LABEL},
    '{":",   1'b0, 1'b1, TK_COLON},
    '{"i",   1'b0, 1'b0, TK_EOF},
    '{"f",   1'b0, 1'b1, TK_IF},
    '{"g",   1'b0, 1'b0, TK_EOF},
    '{"o",   1'b0, 1'b0, TK_EOF},
    '{"t",   1'b0, 1'b0, TK_EOF},
    '{"o",   1'b0, 1'b1, TK_GOTO},
    '{"p",   1'b0, 1'b0, TK_EOF},
    '{"r",   1'b0, 1'b0, TK_EOF},
    '{"i",   1'b0, 1'b0, TK_EOF},
    '{"n",   1'b0, 1'b0, TK_EOF},
    '{"t",   1'b0, 1'b1, TK_PRINT},
    '{"*",   1'b0, 1'b0, TK_EOF},
    '{8'hFF, 1'b1, 1'b1, TK_EOF}      // End of input flushes the star; the byte is ignored.
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Checking model
  // ---------------------------------------------------------------------------------------

  // Append one expected token, stamped with the current line (saturated to 16 bits).
  task automatic push_token(input logic [4:0] kind, input logic [30:0] value,
                            input logic [1:0] err);
    result_t tok;
    tok.token_kind   = kind;
    tok.number_value = value;
    tok.line_number  = (line_count > 65535) ? 16'hFFFF : 16'(line_count);
    tok.error_code   = err;
    tok.last_of_run  = 1'b0;
    expected_tokens.push_back(tok);
    step_results++;
    step_last_kind = kind;
  endtask

  // An error token halts the scanner until reset.
  task automatic halt_with(input logic [1:0] err);
    halted    = 1'b1;
    scan_mode = SCAN_IDLE;
    push_token(TK_EOF, '0, err);
  endtask

  // A character seen with no token pending.
  task automatic scan_fresh(input logic [7:0] c);
    logic [4:0] kind;
    scan_mode = SCAN_IDLE;
    if (c == " " || c == "\t") begin
      // Blanks only separate tokens.
    end else if (c == "\n") begin
      if (line_count != '1) line_count++;
    end else if (c >= "0" && c <= "9") begin
      num_acc = 31'(c - "0");
      // With a small limit even the first digit can be out of range.
      if (num_acc > number_limit) halt_with(ERR_RANGE);
      else scan_mode = SCAN_NUMBER;
    end else if (c == "*") begin
      scan_mode = SCAN_STAR;
    end else if (c == "g" || c == "i" || c == "p") begin
      kw_kind   = (c == "g") ? KW_GOTO : (c == "i") ? KW_IF : KW_PRINT;
      kw_pos    = 3'd1;
      scan_mode = SCAN_KEYWORD;
    end else begin
      case (c)
        "+":     kind = TK_PLUS;
        "-":     kind = TK_MINUS;
        "/":     kind = TK_DIV;
        "=":     kind = TK_ASSIGN;
        "(":     kind = TK_LPAREN;
        ")":     kind = TK_RPAREN;
        "[":     kind = TK_LBRACK;
        "]":     kind = TK_RBRACK;
        "m":     kind = TK_MEM;
        "L":     kind = TK_LABEL;
        ":":     kind = TK_COLON;
        default: kind = TK_EOF;
      endcase
      if (kind == TK_EOF) halt_with(ERR_CHAR);
      else push_token(kind, '0, ERR_NONE);
    end
  endtask

  // Work out the tokens that one accepted item causes.
  task automatic tokenize_char(input logic [7:0] c, input bit eoi);
    longint next_value;
    step_results = 0;
    if (halted) return;
    if (eoi) begin
      if (scan_mode == SCAN_KEYWORD) begin
        halt_with(ERR_CHAR);
      end else begin
        if (scan_mode == SCAN_NUMBER) push_token(TK_NUM, num_acc, ERR_NONE);
        else if (scan_mode == SCAN_STAR) push_token(TK_TIMES, '0, ERR_NONE);
        scan_mode = SCAN_IDLE;
        num_acc   = '0;
        kw_kind   = KW_NONE;
        kw_pos    = '0;
        push_token(TK_EOF, '0, ERR_NONE);
      end
    end else begin
      case (scan_mode)
        SCAN_NUMBER: begin
          if (c >= "0" && c <= "9") begin
            next_value = longint'(num_acc) * 10 + longint'(c - "0");
            if (next_value > number_limit) halt_with(ERR_RANGE);
            else num_acc = 31'(next_value);
          end else begin
            push_token(TK_NUM, num_acc, ERR_NONE);
            num_acc = '0;
            scan_fresh(c);
          end
        end
        SCAN_STAR: begin
          scan_mode = SCAN_IDLE;
          if (c == "*") begin
            push_token(TK_POWER, '0, ERR_NONE);
          end else begin
            push_token(TK_TIMES, '0, ERR_NONE);
            scan_fresh(c);
          end
        end
        SCAN_KEYWORD: begin
          if (kw_kind == KW_NONE || kw_pos >= kw_spelling[kw_kind].len() ||
              kw_spelling[kw_kind][kw_pos] != c) begin
            halt_with(ERR_CHAR);
          end else begin
            kw_pos++;
            if (kw_pos == kw_spelling[kw_kind].len()) begin
              scan_mode = SCAN_IDLE;
              push_token(kw_result[kw_kind], '0, ERR_NONE);
              kw_kind = KW_NONE;
              kw_pos  = '0;
            end
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (step_results > 0) expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------------------

  // Offer one item and return at the falling edge after it was taken. The valid line stays
  // high, so items can be taken back to back; a random gap lowers it first.
  task automatic send_item(input logic [7:0] c, input bit eoi);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.char_code    = c;
    in_if.end_of_input = eoi;
    do @(posedge clk); while (!in_if.ready);
    tokenize_char(c, eoi);
    items_sent++;
    prev_char_digit = !eoi && c >= "0" && c <= "9";
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected token, then give the pipeline time to settle.
  task automatic wait_for_drain();
    in_if.valid = 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The limit is only changed while the block has nothing in flight.
  task automatic write_limit(input logic [30:0] value);
    wait_for_drain();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    number_limit = value;
  endtask

  // Mostly well-formed text with random content: numbers that fit the current limit,
  // operators, stars, whole keywords and blanks, with an end of input now and then.
  // Two numbers are never run together, since the merged value could break the limit.
  task automatic send_random_text(input int n_items);
    int first_item;
    int pick;
    int k;
    longint unsigned value;
    string digits;
    first_item = items_sent;
    while (items_sent - first_item < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        case ($urandom_range(0, 3))
          0:       value = $urandom_range(0, 9) % (longint'(number_limit) + 1);
          1:       value = number_limit;
          default: value = $urandom % (longint'(number_limit) + 1);
        endcase
        digits = $sformatf("%0d", value);
        if ($urandom_range(0, 5) == 0) digits = {"0", digits};
        if (prev_char_digit) send_item(" ", 1'b0);
        for (int j = 0; j < digits.len(); j++) send_item(digits[j], 1'b0);
      end else if (pick < 45) begin
        send_item(single_chars[$urandom_range(0, single_chars.len() - 1)], 1'b0);
      end else if (pick < 55) begin
        send_item("*", 1'b0);
      end else if (pick < 67) begin
        k = $urandom_range(1, 3);
        for (int j = 0; j < kw_spelling[k].len(); j++) send_item(kw_spelling[k][j], 1'b0);
      end else if (pick < 87) begin
        send_item(blank_chars[$urandom_range(0, 2)], 1'b0);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    // Close the phase so that no token is left pending across a limit change.
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side: ready pattern and token check
  // ---------------------------------------------------------------------------------------

  // Ready follows random stall bursts while idling is on. A requested hold-off keeps ready
  // low for a long stretch, counted here, so that the block fills and stalls its input.
  initial begin : token_sink
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_left        = LONG_HOLD_CYCLES;
        hold_off_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(1, 12) - 1;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : token_check
    result_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: token_kind mismatch, expected no token, actual %0d (error %0d)",
                 $time, out_if.token_kind, out_if.error_code);
      end else begin
        want = expected_tokens.pop_front();
        compare_field("token_kind", want.token_kind, out_if.token_kind);
        compare_field("number_value", want.number_value, out_if.number_value);
        compare_field("line_number", want.line_number, out_if.line_number);
        compare_field("error_code", want.error_code, out_if.error_code);
        compare_field("last_of_run", want.last_of_run, out_if.last_of_run);
      end
    end
  end

  // The run is cut off when nothing moves on either channel for too long. The longest
  // quiet stretch of a correct run is the long hold-off plus a burst or two.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    directed_row_t row;
    int kw;
    int cut;
    string overflow_text;
    string bad_chars = "!#$%&,.;<>?@^_{}|~AZaxyzMl";
    string after_halt = "+7 *\n(";

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.char_code    = '0;
    in_if.end_of_input = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table under the reset limit. Typed rows cross-check the model against the
    // language definition; all rows are checked on the output side like any other item.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_table[i];
      send_item(row.ch, row.eoi);
      if (row.typed && (step_results == 0 || step_last_kind != row.kind)) begin
        mismatches++;
        $display("%0t: directed row %0d token_kind mismatch, expected %0d, actual %0d",
                 $time, i, row.kind, step_last_kind);
      end
    end

    // Limit at one, so only 0 and 1 are legal numbers.
    write_limit(31'd1);
    send_random_text(100);

    // Middle limit. The output side holds off for a long stretch while input keeps coming.
    write_limit(31'($urandom_range(10, 99999)));
    idling_on        = 1'b0;
    hold_off_pending = 1'b1;
    send_random_text(40);
    idling_on = 1'b1;
    send_random_text(80);

    // Reset limit, written explicitly; numbers of exactly the limit show up here.
    write_limit(LIMIT_RESET);
    send_random_text(100);

    // Last part, no idling. A few newlines, then more random text.
    idling_on = 1'b0;
    repeat (12) send_item("\n", 1'b0);
    send_random_text(40);

    // One error to finish, since it halts the block for good.
    kw  = $urandom_range(1, 3);
    cut = $urandom_range(1, kw_spelling[kw].len() - 1);
    case ($urandom_range(0, 3))
      0: begin
        // An unknown character, sometimes one with the top bit set.
        if ($urandom_range(0, 1)) send_item(8'($urandom_range(128, 255)), 1'b0);
        else send_item(bad_chars[$urandom_range(0, bad_chars.len() - 1)], 1'b0);
      end
      1: begin
        // A number one above the limit. With a limit below nine the first digit trips it.
        if ($urandom_range(0, 1)) write_limit(31'($urandom_range(1, 8)));
        overflow_text = $sformatf("%0d", longint'(number_limit) + 1);
        for (int j = 0; j < overflow_text.len(); j++) send_item(overflow_text[j], 1'b0);
      end
      2: begin
        // A keyword broken by a character that is legal elsewhere.
        for (int j = 0; j < cut; j++) send_item(kw_spelling[kw][j], 1'b0);
        send_item(")", 1'b0);
      end
      default: begin
        // End of input in the middle of a keyword.
        for (int j = 0; j < cut; j++) send_item(kw_spelling[kw][j], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase

    // Once halted, the block takes items but must give no tokens at all.
    for (int j = 0; j < after_halt.len(); j++) send_item(after_halt[j], 1'b0);
    send_item(8'h5A, 1'b1);

    wait_for_drain();
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/clt_pkg.sv
hw/rtl/clt_if.sv
hw/rtl/clt_front.sv
hw/rtl/clt_back.sv
hw/rtl/calc_language_tokenizer.sv
hw/rtl/clt_checker.sv
verif/tb_calc_language_tokenizer.sv
